// ----- hdl/led_cube_pwm_scan_unit_macros.svh -----
// assertion macros shared by the led cube scan unit checker
// no dependencies; included by the checker file
`ifndef LED_CUBE_PWM_SCAN_UNIT_MACROS_SVH
`define LED_CUBE_PWM_SCAN_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LCPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcps check failed");

// next-cycle implication, disabled during reset
`define LCPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcps check failed");

`endif

// ----- hdl/lcps_pkg.sv -----
// constants, request codes and result beat type for the led cube scan unit
// no dependencies
package lcps_pkg;

   localparam int LEDS_PER_PLANE = 64;
   localparam int PWM_STEPS      = 32;
   localparam int MAX_PLANES     = 8;

   localparam int STEP_W  = 5;
   localparam int PLANE_W = 3;
   localparam int LEVEL_W = 5;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 4;
   localparam int MASK_W  = 64;

   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_COMMIT = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;

   localparam logic [COUNT_W-1:0] PLANE_COUNT_RESET = COUNT_W'(MAX_PLANES);

   typedef struct packed {
      logic                accepted;
      logic [MASK_W-1:0]   led_mask;
      logic [STEP_W-1:0]   pwm_step;
      logic [PLANE_W-1:0]  plane_index;
      logic                plane_latch;
      logic                plane_shift_valid;
      logic                plane_shift_bit;
      logic                underrun;
   } rsp_type;

endpackage

// ----- hdl/led_cube_pwm_scan_unit.sv -----
// led cube pwm scan unit: double-buffered level banks, pwm step and plane scan
// depends on lcps_pkg
//
// usage
//   req channel (req_valid/req_ready): one beat is a request: write a 5-bit
//   level for one led into the back bank, commit the back bank, or a pwm tick.
//   rsp channel (rsp_valid/rsp_ready): exactly one result beat per request,
//   in request order. writes and commits report only rsp_accepted; a tick
//   reports the led mask for the new step, the step, plane and scan strobes.
//   csr channel (csr_valid/csr_ready): writes plane_count; always ready.
//   the user must write it only while no request is in flight; the block does not enforce this.
// result path and throughput
//   results are registered in the output register, or the skid register while
//   the output is held; one request per cycle is sustained while results are taken;
//   the 64 level compares and counter updates sit between the banks and those registers.
// stall
//   a two-entry result queue (output register plus skid register) lets a
//   request be taken while a result waits; req_ready drops only while the
//   skid register is full.
// reset
//   synchronous, active high: both banks clear to zero, step, plane, bank
//   select and pending flag clear, plane_count returns to 8, queue empties.
module led_cube_pwm_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_type,
   input  logic [lcps_pkg::INDEX_W-1:0]  req_led_index,
   input  logic [lcps_pkg::LEVEL_W-1:0]  req_level,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [lcps_pkg::MASK_W-1:0]   rsp_led_mask,
   output logic [lcps_pkg::STEP_W-1:0]   rsp_pwm_step,
   output logic [lcps_pkg::PLANE_W-1:0]  rsp_plane_index,
   output logic                          rsp_plane_latch,
   output logic                          rsp_plane_shift_valid,
   output logic                          rsp_plane_shift_bit,
   output logic                          rsp_underrun,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lcps_pkg::COUNT_W-1:0]  csr_plane_count
);

   // level banks: bank b, led i; each led's comparator reads its front-bank entry
   logic [lcps_pkg::LEVEL_W-1:0] level_ff [2][lcps_pkg::LEDS_PER_PLANE];

   logic                         front_sel_ff, front_sel_in;
   logic                         pending_ff, pending_in;
   logic [lcps_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [lcps_pkg::PLANE_W-1:0] plane_ff, plane_in;
   logic [lcps_pkg::COUNT_W-1:0] plane_count_ff;

   // result queue
   lcps_pkg::rsp_type out_ff, out_in, skid_ff, skid_in, result;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic                         req_fire;
   logic                         out_fire;
   logic                         wr_en;
   logic                         wrap;
   logic [lcps_pkg::STEP_W-1:0]  step_next;
   logic [lcps_pkg::COUNT_W-1:0] eff_planes;
   logic [lcps_pkg::COUNT_W-1:0] plane_inc;
   logic [lcps_pkg::MASK_W-1:0]  mask;

   assign req_ready = !skid_valid_ff;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign out_fire  = out_valid_ff && rsp_ready;

   // step and plane arithmetic
   assign wrap      = (step_ff == lcps_pkg::STEP_W'(lcps_pkg::PWM_STEPS - 1));
   assign step_next = wrap ? '0 : step_ff + 1'b1;
   assign plane_inc = {1'b0, plane_ff} + 1'b1;

   // zero acts as one plane, anything above the maximum as the maximum
   always_comb begin
      if (plane_count_ff == '0) begin
         eff_planes = lcps_pkg::COUNT_W'(1);
      end else if (plane_count_ff > lcps_pkg::COUNT_W'(lcps_pkg::MAX_PLANES)) begin
         eff_planes = lcps_pkg::COUNT_W'(lcps_pkg::MAX_PLANES);
      end else begin
         eff_planes = plane_count_ff;
      end
   end

   // mask for the new step; at step zero every led is on, so the bank
   // swap on wrap never changes the mask and the current front bank serves
   always_comb begin
      mask = '0;
      for (int i = 0; i < lcps_pkg::LEDS_PER_PLANE; i++) begin
         mask[i] = (level_ff[front_sel_ff][i] >= step_next);
      end
   end

   // one request against the current state
   always_comb begin
      result       = '0;
      front_sel_in = front_sel_ff;
      pending_in   = pending_ff;
      step_in      = step_ff;
      plane_in     = plane_ff;
      wr_en        = 1'b0;
      case (req_type)
         lcps_pkg::REQ_WRITE: begin
            if (!pending_ff && (int'(req_led_index) < lcps_pkg::LEDS_PER_PLANE)) begin
               wr_en           = 1'b1;
               result.accepted = 1'b1;
            end
         end
         lcps_pkg::REQ_COMMIT: begin
            if (!pending_ff) begin
               pending_in      = 1'b1;
               result.accepted = 1'b1;
            end
         end
         lcps_pkg::REQ_TICK: begin
            result.accepted    = 1'b1;
            result.plane_latch = (step_ff == '0);
            step_in            = step_next;
            if (wrap) begin
               // swap banks if a frame is ready, else flag the underrun
               if (pending_ff) begin
                  front_sel_in = !front_sel_ff;
               end else begin
                  result.underrun = 1'b1;
               end
               pending_in = 1'b0;
               plane_in   = (plane_inc >= eff_planes) ? '0
                                                      : plane_inc[lcps_pkg::PLANE_W-1:0];
               result.plane_shift_valid = 1'b1;
               // walking zero: a zero enters when leaving plane 0
               result.plane_shift_bit   = (plane_ff != '0);
            end
            result.led_mask    = mask;
            result.pwm_step    = step_next;
            result.plane_index = plane_in;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // result queue steering: output slot refills from skid first
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_fire || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
         end else begin
            out_in = result;
         end
         out_valid_in  = skid_valid_ff || req_fire;
         skid_valid_in = 1'b0;
      end else if (req_fire) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   // control state and banks
   always_ff @(posedge clock) begin
      if (reset) begin
         front_sel_ff   <= 1'b0;
         pending_ff     <= 1'b0;
         step_ff        <= '0;
         plane_ff       <= '0;
         plane_count_ff <= lcps_pkg::PLANE_COUNT_RESET;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
         for (int b = 0; b < 2; b++) begin
            for (int i = 0; i < lcps_pkg::LEDS_PER_PLANE; i++) begin
               level_ff[b][i] <= '0;
            end
         end
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_valid && csr_ready) begin
            plane_count_ff <= csr_plane_count;
         end
         if (req_fire) begin
            front_sel_ff <= front_sel_in;
            pending_ff   <= pending_in;
            step_ff      <= step_in;
            plane_ff     <= plane_in;
            if (wr_en) begin
               // back bank is the one not being displayed
               level_ff[!front_sel_ff][req_led_index] <= req_level;
            end
         end
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_accepted          = out_ff.accepted;
   assign rsp_led_mask          = out_ff.led_mask;
   assign rsp_pwm_step          = out_ff.pwm_step;
   assign rsp_plane_index       = out_ff.plane_index;
   assign rsp_plane_latch       = out_ff.plane_latch;
   assign rsp_plane_shift_valid = out_ff.plane_shift_valid;
   assign rsp_plane_shift_bit   = out_ff.plane_shift_bit;
   assign rsp_underrun          = out_ff.underrun;

endmodule

// ----- hdl/lcps_checker.sv -----
// port-level checker for the led cube scan unit, bound to the top level
// depends on lcps_pkg and led_cube_pwm_scan_unit_macros.svh
`include "led_cube_pwm_scan_unit_macros.svh"

module lcps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_accepted,
   input logic [lcps_pkg::MASK_W-1:0]   rsp_led_mask,
   input logic [lcps_pkg::STEP_W-1:0]   rsp_pwm_step,
   input logic [lcps_pkg::PLANE_W-1:0]  rsp_plane_index,
   input logic                          rsp_plane_latch,
   input logic                          rsp_plane_shift_valid,
   input logic                          rsp_underrun
);

   // a stalled result beat holds
   `LCPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_mask) && $stable(rsp_pwm_step) && $stable(rsp_plane_index))

   // rejected or unknown requests carry nothing but zeros
   `LCPS_ASSERT_NOW(a_reject_zero, clock, reset, rsp_valid && !rsp_accepted, rsp_led_mask == '0 && rsp_pwm_step == '0 && rsp_plane_index == '0 && !rsp_plane_latch && !rsp_plane_shift_valid)

   // plane shift only on the step wrap
   `LCPS_ASSERT_NOW(a_shift_on_wrap, clock, reset, rsp_valid && rsp_plane_shift_valid, rsp_pwm_step == '0 && rsp_led_mask == '1)

   // underrun is reported only together with a wrap
   `LCPS_ASSERT_NOW(a_underrun_wrap, clock, reset, rsp_valid && rsp_underrun, rsp_plane_shift_valid && rsp_accepted)

   // latch pulse means the step just left zero
   `LCPS_ASSERT_NOW(a_latch_step, clock, reset, rsp_valid && rsp_plane_latch, rsp_pwm_step == lcps_pkg::STEP_W'(1))

endmodule

bind led_cube_pwm_scan_unit lcps_checker u_lcps_checker (.*);

// ----- dv/tb_top.sv -----
// self-checking testbench for led_cube_pwm_scan_unit: a tracker class mirrors the
// level banks, step and plane counters and checks each result beat in order
// depends on lcps_pkg and the led_cube_pwm_scan_unit rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // request code the block does not define; must leave all state alone
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int BEATS_PER_PHASE = 100;
   localparam int HOLD_CYCLES     = 80;
   localparam int BURST_BEATS     = 24;
   localparam int DRAIN_CYCLES    = 4;
   localparam int RUN_LIMIT       = 400000;

   // plane counts walked through, one per phase; the first is the reset value
   localparam logic [lcps_pkg::COUNT_W-1:0] PHASE_COUNTS [8] = '{
      4'd8, 4'd15, 4'd2, 4'd0, 4'd1, 4'd5, 4'd8, 4'd3
   };

   // ------------------------------------------------------------------
   // tracker: mirror of the scan state plus the queue of results due
   // ------------------------------------------------------------------
   class cube_scan_tracker;
      logic [lcps_pkg::LEVEL_W-1:0] level_mem [2][lcps_pkg::LEDS_PER_PLANE];
      bit                           front_sel;
      bit                           frame_ready;
      logic [lcps_pkg::STEP_W-1:0]  step;
      logic [lcps_pkg::PLANE_W-1:0] plane;
      logic [lcps_pkg::COUNT_W-1:0] plane_count;
      lcps_pkg::rsp_type            due_beats [$];
      int                           errors;

      function new();
         foreach (level_mem[b, i]) level_mem[b][i] = '0;
         front_sel   = 1'b0;
         frame_ready = 1'b0;
         step        = '0;
         plane       = '0;
         plane_count = lcps_pkg::PLANE_COUNT_RESET;
         errors      = 0;
      endfunction

      function void set_plane_count(logic [lcps_pkg::COUNT_W-1:0] value);
         plane_count = value;
      endfunction

      function int outstanding();
         return due_beats.size();
      endfunction

      // advance the mirror by one request beat; returns the accepted flag
      function bit note_request(logic [1:0] kind, logic [lcps_pkg::INDEX_W-1:0] idx,
                                logic [lcps_pkg::LEVEL_W-1:0] lvl);
         lcps_pkg::rsp_type           r;
         logic [lcps_pkg::STEP_W-1:0] next_step;
         int                          planes;
         int                          next_plane;
         r = '0;
         case (kind)
            lcps_pkg::REQ_WRITE: begin
               // writes land in the back bank unless a frame waits for the swap
               if (!frame_ready) begin
                  level_mem[!front_sel][idx] = lvl;
                  r.accepted = 1'b1;
               end
            end
            lcps_pkg::REQ_COMMIT: begin
               if (!frame_ready) begin
                  frame_ready = 1'b1;
                  r.accepted  = 1'b1;
               end
            end
            lcps_pkg::REQ_TICK: begin
               next_step     = step + 1'b1;    // wraps modulo 32 by width
               r.accepted    = 1'b1;
               r.plane_latch = (step == '0);
               step          = next_step;
               if (next_step == '0) begin
                  if (frame_ready) front_sel = !front_sel;
                  else r.underrun = 1'b1;
                  frame_ready = 1'b0;
                  planes = int'(plane_count);
                  if (planes == 0) planes = 1;
                  if (planes > lcps_pkg::MAX_PLANES) planes = lcps_pkg::MAX_PLANES;
                  r.plane_shift_valid = 1'b1;
                  r.plane_shift_bit   = (plane != '0);
                  next_plane = int'(plane) + 1;
                  plane = (next_plane >= planes) ? '0
                                                 : lcps_pkg::PLANE_W'(next_plane);
               end
               for (int i = 0; i < lcps_pkg::LEDS_PER_PLANE; i++)
                  r.led_mask[i] = (level_mem[front_sel][i] >= next_step);
               r.pwm_step    = step;
               r.plane_index = plane;
            end
            default: ;
         endcase
         due_beats.push_back(r);
         return r.accepted;
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(lcps_pkg::rsp_type got);
         lcps_pkg::rsp_type want;
         if (due_beats.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
            return;
         end
         want = due_beats.pop_front();
         compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
         compare_field("led_mask", want.led_mask, got.led_mask);
         compare_field("pwm_step", 64'(want.pwm_step), 64'(got.pwm_step));
         compare_field("plane_index", 64'(want.plane_index), 64'(got.plane_index));
         compare_field("plane_latch", 64'(want.plane_latch), 64'(got.plane_latch));
         compare_field("plane_shift_valid", 64'(want.plane_shift_valid),
                       64'(got.plane_shift_valid));
         compare_field("plane_shift_bit", 64'(want.plane_shift_bit),
                       64'(got.plane_shift_bit));
         compare_field("underrun", 64'(want.underrun), 64'(got.underrun));
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset and block signals
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid       = 1'b0;
   logic                           req_ready;
   logic [1:0]                     req_type        = lcps_pkg::REQ_WRITE;
   logic [lcps_pkg::INDEX_W-1:0]   req_led_index   = '0;
   logic [lcps_pkg::LEVEL_W-1:0]   req_level       = '0;
   logic                           rsp_valid;
   logic                           rsp_ready       = 1'b0;
   logic                           rsp_accepted;
   logic [lcps_pkg::MASK_W-1:0]    rsp_led_mask;
   logic [lcps_pkg::STEP_W-1:0]    rsp_pwm_step;
   logic [lcps_pkg::PLANE_W-1:0]   rsp_plane_index;
   logic                           rsp_plane_latch;
   logic                           rsp_plane_shift_valid;
   logic                           rsp_plane_shift_bit;
   logic                           rsp_underrun;
   logic                           csr_valid       = 1'b0;
   logic                           csr_ready;
   logic [lcps_pkg::COUNT_W-1:0]   csr_plane_count = '0;

   cube_scan_tracker tracker = new();

   // quiet: neither side idles; hold_off_req asks the receiver for a long stall
   bit          quiet        = 1'b0;
   bit          hold_off_req = 1'b0;
   int          useful_beats = 0;
   int unsigned cycle_count  = 0;

   always #10 clock = ~clock;

   led_cube_pwm_scan_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_type              (req_type),
      .req_led_index         (req_led_index),
      .req_level             (req_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_accepted          (rsp_accepted),
      .rsp_led_mask          (rsp_led_mask),
      .rsp_pwm_step          (rsp_pwm_step),
      .rsp_plane_index       (rsp_plane_index),
      .rsp_plane_latch       (rsp_plane_latch),
      .rsp_plane_shift_valid (rsp_plane_shift_valid),
      .rsp_plane_shift_bit   (rsp_plane_shift_bit),
      .rsp_underrun          (rsp_underrun),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_plane_count       (csr_plane_count)
   );

   // ------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------
   // idle length drawn from three ranges: most often the shortest, rarely a long stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(20, 40);
   endfunction

   function automatic int sender_gap();
      if (quiet || $urandom_range(0, 1) == 0) return 0;
      return pick_gap();
   endfunction

   // levels lean on the extremes so full-on and full-off leds show up often
   function automatic logic [lcps_pkg::LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return lcps_pkg::LEVEL_W'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // called at a rising edge; returns at the edge that takes the beat,
   // with valid still high so the next beat can follow back to back
   task automatic send_req(input logic [1:0] kind,
                           input logic [lcps_pkg::INDEX_W-1:0] idx,
                           input logic [lcps_pkg::LEVEL_W-1:0] lvl);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_led_index <= idx;
      req_level     <= lvl;
      do @(posedge clock); while (!req_ready);
      if (tracker.note_request(kind, idx, lvl)) useful_beats++;
   endtask

   // drop valid and wait until every result due has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // block is idle here; one beat on the csr channel
   task automatic write_plane_count(input logic [lcps_pkg::COUNT_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_plane_count <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_plane_count(value);
      csr_valid <= 1'b0;
   endtask

   // one frame: a few writes, usually a commit, then ticks, usually up to the wrap,
   // with some stray requests of any kind mixed in
   task automatic run_frame();
      bit fill_all;
      int writes;
      int ticks;
      quiet    = ($urandom_range(0, 4) == 0);
      fill_all = ($urandom_range(0, 11) == 0);
      writes   = fill_all ? lcps_pkg::LEDS_PER_PLANE : $urandom_range(0, 10);
      for (int i = 0; i < writes; i++)
         send_req(lcps_pkg::REQ_WRITE,
                  fill_all ? lcps_pkg::INDEX_W'(i) : lcps_pkg::INDEX_W'($urandom),
                  pick_level());
      if ($urandom_range(0, 6) != 0)
         send_req(lcps_pkg::REQ_COMMIT, lcps_pkg::INDEX_W'($urandom),
                  lcps_pkg::LEVEL_W'($urandom));
      // usually run to the wrap, sometimes stop at a random step
      ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 40)
                                          : lcps_pkg::PWM_STEPS - int'(tracker.step);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_req(2'($urandom_range(0, 3)), lcps_pkg::INDEX_W'($urandom),
                     lcps_pkg::LEVEL_W'($urandom));
         send_req(lcps_pkg::REQ_TICK, lcps_pkg::INDEX_W'($urandom),
                  lcps_pkg::LEVEL_W'($urandom));
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      int min_plane;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every request kind, refusals while pending
      send_req(lcps_pkg::REQ_WRITE, 6'd0, 5'd31);
      send_req(lcps_pkg::REQ_WRITE, 6'd63, 5'd0);
      send_req(lcps_pkg::REQ_WRITE, 6'd63, 5'd31);
      send_req(lcps_pkg::REQ_WRITE, 6'd1, 5'd1);
      send_req(lcps_pkg::REQ_WRITE, 6'd62, 5'd30);
      send_req(REQ_UNUSED, 6'd63, 5'd31);
      send_req(REQ_UNUSED, 6'd0, 5'd0);
      send_req(lcps_pkg::REQ_TICK, 6'd0, 5'd0);   // first tick: latch, front bank zero
      send_req(lcps_pkg::REQ_COMMIT, 6'd63, 5'd31);
      send_req(lcps_pkg::REQ_COMMIT, 6'd0, 5'd0); // refused, frame already pending
      send_req(lcps_pkg::REQ_WRITE, 6'd5, 5'd7);  // refused, frame already pending
      send_req(lcps_pkg::REQ_TICK, 6'd63, 5'd31);
      send_req(REQ_UNUSED, 6'd21, 5'd10);
      send_req(lcps_pkg::REQ_TICK, 6'd42, 5'd21);

      foreach (PHASE_COUNTS[p]) begin
         if (p > 0) begin
            // sender pauses until the block is empty, then the count changes
            wait_drained();
            write_plane_count(PHASE_COUNTS[p]);
         end
         // before lowering the count, push the plane counter high so the
         // next phase starts with the plane beyond the new count
         min_plane = (PHASE_COUNTS[p] == 4'd15) ? 6 : 0;
         if (p == 2) begin
            // receiver stalls for a long stretch while ticks keep coming
            hold_off_req <= 1'b1;
            quiet = 1'b1;
            repeat (BURST_BEATS)
               send_req(lcps_pkg::REQ_TICK, lcps_pkg::INDEX_W'($urandom),
                        lcps_pkg::LEVEL_W'($urandom));
            quiet = 1'b0;
         end
         while (useful_beats < (p + 1) * BEATS_PER_PHASE || int'(tracker.plane) < min_plane)
            run_frame();
      end

      wait_drained();
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side: random stalls, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : result_side
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            hold_off_req <= 1'b0;
            rsp_ready    <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // every result beat taken is checked against the oldest one due
   always @(posedge clock) begin : result_monitor
      lcps_pkg::rsp_type seen_beat;
      if (!reset && rsp_valid && rsp_ready) begin
         seen_beat.accepted          = rsp_accepted;
         seen_beat.led_mask          = rsp_led_mask;
         seen_beat.pwm_step          = rsp_pwm_step;
         seen_beat.plane_index       = rsp_plane_index;
         seen_beat.plane_latch       = rsp_plane_latch;
         seen_beat.plane_shift_valid = rsp_plane_shift_valid;
         seen_beat.plane_shift_bit   = rsp_plane_shift_bit;
         seen_beat.underrun          = rsp_underrun;
         tracker.check_result(seen_beat);
      end
   end

   // hard stop if the run hangs, e.g. a result that never comes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lcps_pkg.sv
hdl/led_cube_pwm_scan_unit.sv
hdl/lcps_checker.sv
dv/tb_top.sv
